// ----- rtl/core/lmbs_pkg.sv -----
// Package for the local map box slider: widths, types and helper functions.
`default_nettype none
package lmbs_pkg;

  localparam int CoordW  = 32;
  localparam int RegW    = 31;
  localparam int NumAxes = 3;
  localparam int NumRegs = 3;
  localparam int IdxW    = 2;

  // Register indexes on the configuration port
  typedef enum logic [IdxW-1:0] {
    REG_CUBE_LEN    = 2'd0,
    REG_TRIGGER     = 2'd1,
    REG_SHIFT_FLOOR = 2'd2
  } reg_idx_t;

  localparam logic [RegW-1:0] CubeLenRst    = 31'd1024000;
  localparam logic [RegW-1:0] TriggerRst    = 31'd460800;
  localparam logic [RegW-1:0] ShiftFloorRst = 31'd153600;

  // Reciprocal of 5 scaled by 2**34, exact for 32 bit dividends
  localparam logic [31:0] RecipFive = 32'hCCCCCCCD;
  localparam int          RecipSh   = 34;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [NumAxes-1:0][CoordW-1:0] vec3_t;

  // Saturate a 33 bit signed value into the 32 bit signed range
  function automatic coord_t sat33(input logic signed [CoordW:0] v);
    coord_t res;
    if (v[CoordW] != v[CoordW-1]) begin
      res = v[CoordW] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    end else begin
      res = v[CoordW-1:0];
    end
    return res;
  endfunction

  // floor(9*r/20) for a remainder r below 20
  function automatic logic [3:0] nine_twentieths(input logic [4:0] r);
    logic [3:0] q;
    case (r)
      5'd0, 5'd1, 5'd2:    q = 4'd0;
      5'd3, 5'd4:          q = 4'd1;
      5'd5, 5'd6:          q = 4'd2;
      5'd7, 5'd8:          q = 4'd3;
      5'd9, 5'd10, 5'd11:  q = 4'd4;
      5'd12, 5'd13:        q = 4'd5;
      5'd14, 5'd15:        q = 4'd6;
      5'd16, 5'd17:        q = 4'd7;
      5'd18, 5'd19:        q = 4'd8;
      default:             q = 4'd0;
    endcase
    return q;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/local_map_box_slider_core.sv -----
// Local map cube slider: tracks the map cube and emits removal boxes per position.
// Path: a position is registered in the input register at its input transaction; its boxes
// go into the box buffer when it advances, and the result port offers them from there.
// Throughput: one position per cycle when it moves no face and the move distance is valid;
// else its boxes (up to three) drain one by one through the single result port.
// Reset: defaults, cube unplaced; after reset or a write, positions await the move distance.
`default_nettype none
module local_map_box_slider_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration write port
  input  wire logic                          cfg_we,
  input  wire logic [lmbs_pkg::IdxW-1:0]     cfg_idx,
  input  wire logic [lmbs_pkg::RegW-1:0]     cfg_data,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [lmbs_pkg::CoordW-1:0] in_pos_x,
  input  wire logic signed [lmbs_pkg::CoordW-1:0] in_pos_y,
  input  wire logic signed [lmbs_pkg::CoordW-1:0] in_pos_z,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         out_shift_axis,
  output logic signed [lmbs_pkg::CoordW-1:0] out_box_min_x,
  output logic signed [lmbs_pkg::CoordW-1:0] out_box_min_y,
  output logic signed [lmbs_pkg::CoordW-1:0] out_box_min_z,
  output logic signed [lmbs_pkg::CoordW-1:0] out_box_max_x,
  output logic signed [lmbs_pkg::CoordW-1:0] out_box_max_y,
  output logic signed [lmbs_pkg::CoordW-1:0] out_box_max_z,
  output logic                               out_last_box
);
  import lmbs_pkg::*;

  // ---------------------------------------------------------------
  // Configuration registers
  logic [RegW-1:0] cube_len_r, trigger_r, floor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cube_len_r <= CubeLenRst;
      trigger_r  <= TriggerRst;
      floor_r    <= ShiftFloorRst;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_CUBE_LEN:    cube_len_r <= cfg_data;
        REG_TRIGGER:     trigger_r  <= cfg_data;
        REG_SHIFT_FLOOR: floor_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Move distance unit, stage A: diff = len - 2*trigger, q = floor(diff/20)
  logic signed [RegW+1:0] diff;
  logic                   diff_pos;
  logic [RegW-3:0]        quo_n;
  logic [RegW-3+32:0]     quo_prod;
  logic                   mva_pos_r;
  logic [RegW-1:0]        mva_diff_r;
  logic [26:0]            mva_q_r;

  assign diff     = $signed({2'b00, cube_len_r}) - $signed({1'b0, trigger_r, 1'b0});
  assign diff_pos = !diff[RegW+1] && (diff != '0);
  assign quo_n    = diff[RegW-1:2];
  assign quo_prod = quo_n * RecipFive;

  always_ff @(posedge clk) begin
    mva_pos_r  <= diff_pos;
    mva_diff_r <= diff[RegW-1:0];
    mva_q_r    <= quo_prod[RecipSh+26:RecipSh];
  end

  // Stage B: m = 9*q + floor(9*(diff - 20*q)/20), move = max(m, floor), or floor if diff <= 0
  logic [RegW-1:0] mv_twenty_q, mv_rem_full, mv_m, mov_nxt, mov_r;
  logic [4:0]      mv_rem;

  assign mv_twenty_q = {mva_q_r, 4'b0} + {2'b0, mva_q_r, 2'b0};
  assign mv_rem_full = mva_diff_r - mv_twenty_q;
  assign mv_rem      = mv_rem_full[4:0];
  assign mv_m        = {1'b0, mva_q_r, 3'b0} + {4'b0, mva_q_r}
                       + {27'b0, nine_twentieths(mv_rem)};
  assign mov_nxt     = (mva_pos_r && (mv_m > floor_r)) ? mv_m : floor_r;

  always_ff @(posedge clk) begin
    mov_r <= mov_nxt;
  end

  // Pending flags: move distance not yet valid after reset or a register write
  logic [1:0] mv_pend_r;
  logic       mv_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_pend_r <= 2'b11;
    end else begin
      mv_pend_r <= {mv_pend_r[0], cfg_we};
    end
  end

  assign mv_ready = (mv_pend_r == 2'b00) && !cfg_we;

  // ---------------------------------------------------------------
  // Input register
  logic  s1_v_r;
  vec3_t s1_pos_r;
  logic  s1_go;
  logic  in_fire;

  assign in_stall = !rst_n || (s1_v_r && !s1_go);
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (s1_go) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pos_r <= {in_pos_z, in_pos_y, in_pos_x};
    end
  end

  // ---------------------------------------------------------------
  // Cube state and per-axis face tests
  vec3_t cube_low_r, cube_high_r;
  logic  placed_r;

  logic [NumAxes-1:0] hit_low, hit_high, hits;
  vec3_t lo_dn, hi_dn, lo_up, hi_up, place_lo, place_hi;

  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      logic signed [CoordW:0] dl, dh;
      logic [CoordW:0]        al, ah;
      logic signed [CoordW:0] pe, le, he, me, hf;
      pe = {s1_pos_r[i][CoordW-1], s1_pos_r[i]};
      le = {cube_low_r[i][CoordW-1], cube_low_r[i]};
      he = {cube_high_r[i][CoordW-1], cube_high_r[i]};
      me = {2'b00, mov_r};
      hf = {3'b000, cube_len_r[RegW-1:1]};
      dl = pe - le;
      dh = pe - he;
      al = dl[CoordW] ? (~dl + 1'b1) : dl;
      ah = dh[CoordW] ? (~dh + 1'b1) : dh;
      hit_low[i]  = (al <= {2'b00, trigger_r});
      hit_high[i] = !hit_low[i] && (ah <= {2'b00, trigger_r});
      lo_dn[i]    = sat33(le - me);
      hi_dn[i]    = sat33(he - me);
      lo_up[i]    = sat33(le + me);
      hi_up[i]    = sat33(he + me);
      place_lo[i] = sat33(pe - hf);
      place_hi[i] = sat33(pe + hf);
    end
    hits = hit_low | hit_high;
  end

  // ---------------------------------------------------------------
  // Box buffer: one box slot per axis, pending mask drains lowest axis first
  logic [NumAxes-1:0]             ob_pend_r;
  logic [NumAxes-1:0][1:0]        ob_axis_r;
  logic [NumAxes-1:0]             sel_mask;
  logic [1:0]                     sel_idx;
  vec3_t                          ob_min_r [NumAxes];
  vec3_t                          ob_max_r [NumAxes];
  vec3_t                          ob_min_nxt [NumAxes];
  vec3_t                          ob_max_nxt [NumAxes];
  logic                           out_fire, ob_free, ob_load;

  always_comb begin
    sel_mask = ob_pend_r & (~ob_pend_r + 1'b1);
    sel_idx  = 2'd0;
    if (sel_mask[1]) sel_idx = 2'd1;
    if (sel_mask[2]) sel_idx = 2'd2;
  end

  assign out_valid = (ob_pend_r != '0);
  assign out_fire  = out_valid && !out_stall;
  assign ob_free   = (ob_pend_r == '0) || (out_fire && $onehot(ob_pend_r));
  assign s1_go     = s1_v_r && mv_ready && (!placed_r || (hits == '0) || ob_free);
  assign ob_load   = s1_go && placed_r && (hits != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_pend_r <= '0;
    end else if (ob_load) begin
      ob_pend_r <= hits;
    end else if (out_fire) begin
      ob_pend_r <= ob_pend_r & ~sel_mask;
    end
  end

  // Box payload: old cube with the moved bound replaced
  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      ob_min_nxt[i] = cube_low_r;
      ob_max_nxt[i] = cube_high_r;
      if (hit_low[i]) begin
        ob_min_nxt[i][i] = hi_dn[i];
      end else begin
        ob_max_nxt[i][i] = lo_up[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ob_load) begin
      for (int i = 0; i < NumAxes; i++) begin
        ob_axis_r[i] <= 2'(i);
        ob_min_r[i]  <= ob_min_nxt[i];
        ob_max_r[i]  <= ob_max_nxt[i];
      end
    end
  end

  // Cube update: placement on the first position, slides afterwards
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      placed_r    <= 1'b0;
      cube_low_r  <= '0;
      cube_high_r <= '0;
    end else if (s1_go) begin
      placed_r <= 1'b1;
      for (int i = 0; i < NumAxes; i++) begin
        if (!placed_r) begin
          cube_low_r[i]  <= place_lo[i];
          cube_high_r[i] <= place_hi[i];
        end else if (hit_low[i]) begin
          cube_low_r[i]  <= lo_dn[i];
          cube_high_r[i] <= hi_dn[i];
        end else if (hit_high[i]) begin
          cube_low_r[i]  <= lo_up[i];
          cube_high_r[i] <= hi_up[i];
        end
      end
    end
  end

  // Result port
  assign out_shift_axis = ob_axis_r[sel_idx];
  assign out_box_min_x  = ob_min_r[sel_idx][0];
  assign out_box_min_y  = ob_min_r[sel_idx][1];
  assign out_box_min_z  = ob_min_r[sel_idx][2];
  assign out_box_max_x  = ob_max_r[sel_idx][0];
  assign out_box_max_y  = ob_max_r[sel_idx][1];
  assign out_box_max_z  = ob_max_r[sel_idx][2];
  assign out_last_box   = $onehot(ob_pend_r);

  // ---------------------------------------------------------------
  // Assertions
  a_out_needs_cube: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> placed_r)
    else $error("box offered before the cube was placed");

  a_mov_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (mv_pend_r != 2'b00) |-> !s1_go)
    else $error("position advanced with a stale move distance");

  a_held_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_go) |=> (s1_v_r && $stable(s1_pos_r)))
    else $error("held position lost or overwritten");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    ob_load |-> ((ob_pend_r == '0) || (out_fire && $onehot(ob_pend_r))))
    else $error("box buffer reloaded with boxes still pending");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !ob_load) |=> ($countones(ob_pend_r) == $countones($past(ob_pend_r)) - 1))
    else $error("box buffer did not drop exactly one box");

endmodule
`default_nettype wire

// ----- bench/local_map_box_slider_core_tb.sv -----
// Self-checking testbench for the local map cube slider: directed table, then random positions.
module local_map_box_slider_core_tb;
  import lmbs_pkg::*;

  localparam int IdlePct    = 12;
  localparam int TailCycles = 8;
  localparam int StallLimit = 2000;
  localparam int RandPerSet = 24;
  localparam int NumSets    = 5;

  localparam coord_t CoordMax = 32'sh7FFFFFFF;
  localparam coord_t CoordMin = 32'sh80000000;
  localparam logic [RegW-1:0] RegMax = 31'h7FFFFFFF;
  // index past the last register; writes to it are dropped
  localparam logic [IdxW-1:0] RegIdxSpare = 2'd3;

  typedef enum int {FaceNone, FaceLow, FaceHigh} face_t;

  typedef struct packed {
    logic [1:0] axis;
    coord_t     min_x;
    coord_t     min_y;
    coord_t     min_z;
    coord_t     max_x;
    coord_t     max_y;
    coord_t     max_z;
    logic       last;
  } box_t;

  // one stimulus row; n_boxes below zero means the predictor supplies the boxes
  typedef struct packed {
    coord_t             x;
    coord_t             y;
    coord_t             z;
    logic signed [3:0]  n_boxes;
    box_t               b0;
    box_t               b1;
  } pos_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [IdxW-1:0] cfg_idx;
  logic [RegW-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  coord_t in_pos_x, in_pos_y, in_pos_z;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_shift_axis;
  coord_t out_box_min_x, out_box_min_y, out_box_min_z;
  coord_t out_box_max_x, out_box_max_y, out_box_max_z;
  logic out_last_box;

  // predictor copy of registers and cube
  logic [RegW-1:0] len_reg   = CubeLenRst;
  logic [RegW-1:0] trig_reg  = TriggerRst;
  logic [RegW-1:0] floor_reg = ShiftFloorRst;
  coord_t cube_lo [3];
  coord_t cube_hi [3];
  bit cube_set = 1'b0;

  box_t step_boxes [$];
  box_t boxes_due [$];
  pos_row_t drill [$];
  int errors = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;

  local_map_box_slider_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_shift_axis (out_shift_axis),
    .out_box_min_x  (out_box_min_x),
    .out_box_min_y  (out_box_min_y),
    .out_box_min_z  (out_box_min_z),
    .out_box_max_x  (out_box_max_x),
    .out_box_max_y  (out_box_max_y),
    .out_box_max_z  (out_box_max_z),
    .out_last_box   (out_last_box)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic coord_t clip_coord(input longint v);
    if (v > longint'(CoordMax)) return CoordMax;
    if (v < longint'(CoordMin)) return CoordMin;
    return coord_t'(v);
  endfunction

  function automatic longint gap_to(input longint p, input longint f);
    return (p >= f) ? p - f : f - p;
  endfunction

  function automatic box_t mk_box(input logic [1:0] axis, input coord_t mnx, input coord_t mny,
                                  input coord_t mnz, input coord_t mxx, input coord_t mxy,
                                  input coord_t mxz, input logic last);
    box_t b;
    b.axis  = axis;
    b.min_x = mnx;
    b.min_y = mny;
    b.min_z = mnz;
    b.max_x = mxx;
    b.max_y = mxy;
    b.max_z = mxz;
    b.last  = last;
    return b;
  endfunction

  // Cube tracker: place on the first position, then slide per axis and collect removal boxes
  function automatic void slide_cube(input coord_t px, input coord_t py, input coord_t pz);
    longint pos [3];
    longint half, span, mv;
    face_t  face [3];
    coord_t o_lo [3], o_hi [3], bmn [3], bmx [3];
    int     a, hits, k;
    box_t   b;
    step_boxes.delete();
    pos[0] = px;
    pos[1] = py;
    pos[2] = pz;
    if (!cube_set) begin
      half = longint'(len_reg >> 1);
      for (a = 0; a < 3; a++) begin
        cube_lo[a] = clip_coord(pos[a] - half);
        cube_hi[a] = clip_coord(pos[a] + half);
      end
      cube_set = 1'b1;
      return;
    end
    // move distance: 0.45 of the slack between the trigger zones, at least the floor
    span = longint'(len_reg) - 2 * longint'(trig_reg);
    mv = longint'(floor_reg);
    if (span > 0 && span * 9 / 20 > mv) mv = span * 9 / 20;
    // face tests use the cube as it stood before this position
    hits = 0;
    for (a = 0; a < 3; a++) begin
      o_lo[a] = cube_lo[a];
      o_hi[a] = cube_hi[a];
      if (gap_to(pos[a], o_lo[a]) <= longint'(trig_reg)) face[a] = FaceLow;
      else if (gap_to(pos[a], o_hi[a]) <= longint'(trig_reg)) face[a] = FaceHigh;
      else face[a] = FaceNone;
      if (face[a] != FaceNone) hits++;
    end
    k = 0;
    for (a = 0; a < 3; a++) begin
      if (face[a] == FaceNone) continue;
      bmn = o_lo;
      bmx = o_hi;
      if (face[a] == FaceLow) begin
        bmn[a] = clip_coord(o_hi[a] - mv);
        cube_lo[a] = clip_coord(o_lo[a] - mv);
        cube_hi[a] = clip_coord(o_hi[a] - mv);
      end else begin
        bmx[a] = clip_coord(o_lo[a] + mv);
        cube_lo[a] = clip_coord(o_lo[a] + mv);
        cube_hi[a] = clip_coord(o_hi[a] + mv);
      end
      k++;
      b = mk_box(a[1:0], bmn[0], bmn[1], bmn[2], bmx[0], bmx[1], bmx[2], k == hits);
      step_boxes.insert(step_boxes.size(), b);
    end
  endfunction

  // Random coordinate, mostly near a face of the current cube
  function automatic coord_t pick_coord(input int a);
    longint face, off;
    int unsigned mode, lim;
    mode = $urandom_range(0, 99);
    face = $urandom_range(0, 1) ? cube_hi[a] : cube_lo[a];
    lim = 32'(longint'(trig_reg) + longint'(trig_reg >> 2) + 64);
    if (mode >= 90) return coord_t'((longint'(cube_lo[a]) + longint'(cube_hi[a])) / 2);
    if (mode >= 70) return coord_t'($urandom);
    if (mode >= 50) off = longint'(trig_reg) + longint'($urandom_range(0, 2)) - 1;
    else off = longint'($urandom_range(0, lim));
    if ($urandom_range(0, 1)) off = -off;
    return clip_coord(face + off);
  endfunction

  task automatic add_row(input coord_t x, input coord_t y, input coord_t z,
                         input int n = -1, input box_t b0 = '0, input box_t b1 = '0);
    pos_row_t r;
    r.x = x;
    r.y = y;
    r.z = z;
    r.n_boxes = 4'(n);
    r.b0 = b0;
    r.b1 = b1;
    drill.insert(drill.size(), r);
  endtask

  // Offer one position, wait for the transaction, then queue its boxes
  task automatic send_pos(input pos_row_t row);
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= row.x;
    in_pos_y <= row.y;
    in_pos_z <= row.z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    slide_cube(row.x, row.y, row.z);
    if (row.n_boxes < 0) begin
      foreach (step_boxes[i]) boxes_due.insert(boxes_due.size(), step_boxes[i]);
    end else begin
      if (step_boxes.size() != row.n_boxes) begin
        errors++;
        $display("%0t: directed row box count: expected %0d, predictor %0d",
                 $time, row.n_boxes, step_boxes.size());
      end
      if (row.n_boxes > 0) boxes_due.insert(boxes_due.size(), row.b0);
      if (row.n_boxes > 1) boxes_due.insert(boxes_due.size(), row.b1);
    end
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [RegW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CUBE_LEN:    len_reg = val;
      REG_TRIGGER:     trig_reg = val;
      REG_SHIFT_FLOOR: floor_reg = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Stop sending, let every pending box out, then allow for in-flight positions
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (boxes_due.size() != 0);
    repeat (TailCycles) @(posedge clk);
  endtask

  task automatic check_field(input string fname, input longint want, input longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
    end
  endtask

  // Result side: compare each transaction against the oldest pending box
  always @(posedge clk) begin
    box_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (boxes_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected box: expected none, actual axis %0d", $time, out_shift_axis);
      end else begin
        want = boxes_due.pop_front();
        check_field("shift_axis", want.axis, out_shift_axis);
        check_field("box_min_x", want.min_x, out_box_min_x);
        check_field("box_min_y", want.min_y, out_box_min_y);
        check_field("box_min_z", want.min_z, out_box_min_z);
        check_field("box_max_x", want.max_x, out_box_max_x);
        check_field("box_max_y", want.max_y, out_box_max_y);
        check_field("box_max_z", want.max_z, out_box_max_z);
        check_field("last_box", want.last, out_last_box);
      end
    end
    out_stall <= !calm && ($urandom_range(0, 99) < IdlePct);
  end

  // Watchdog: too long without any transaction on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    pos_row_t row;
    int set, i;
    logic [RegW-1:0] len_v, trig_v, floor_v;

    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= REG_CUBE_LEN;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_pos_x  <= '0;
    in_pos_y  <= '0;
    in_pos_z  <= '0;
    foreach (cube_lo[a]) begin
      cube_lo[a] = '0;
      cube_hi[a] = '0;
    end

    // Directed rows at reset settings (half side 512000, trigger 460800, move 153600)
    // placement on the range limits saturates the cube bounds
    add_row(CoordMax, CoordMin, 0, 0);
    // far from every face: nothing moves
    add_row(0, 0, 0, 0);
    // x on its high face and y on its low face: two saturating boxes
    add_row(CoordMax, CoordMin, 0, 2,
            mk_box(2'd0, 2146971647, CoordMin, -512000, 2147125247, -2146971648, 512000, 1'b0),
            mk_box(2'd1, 2146971647, -2147125248, -512000, CoordMax, -2146971648, 512000, 1'b1));
    // z one past the trigger distance, then exactly on it
    add_row(0, 0, -51199, 0);
    add_row(0, 0, -51200, 1,
            mk_box(2'd2, 2147125247, CoordMin, 358400, CoordMax, -2147125248, 512000, 1'b1));
    // beyond the high face, on the trigger distance and inside it
    add_row(0, 0, 819200);
    add_row(0, 0, 819201);
    // all three axes at once
    add_row(CoordMax, CoordMin, 0);
    add_row(CoordMin, CoordMax, CoordMin);
    add_row(-1, -1, -1);
    add_row(32'sh55555555, 32'shAAAAAAAA, 32'sh0F0F0F0F);
    add_row(CoordMax, CoordMax, CoordMax);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (drill[r]) send_pos(drill[r]);

    // Random phases, each under its own register setting
    for (set = 0; set < NumSets; set++) begin
      settle();
      case (set)
        0: begin
          len_v = 31'd2000001;
          trig_v = 31'd300000;
          floor_v = 31'd1000;
        end
        1: begin
          len_v = RegMax;
          trig_v = '0;
          floor_v = '0;
        end
        2: begin
          len_v = '0;
          trig_v = RegMax;
          floor_v = RegMax;
        end
        3: begin
          len_v = RegW'($urandom_range(0, 32'h7FFFFFFF));
          trig_v = RegW'($urandom_range(0, 32'h7FFFFFFF));
          floor_v = RegW'($urandom_range(0, 32'h7FFFFFFF));
        end
        default: begin
          len_v = CubeLenRst;
          trig_v = TriggerRst;
          floor_v = ShiftFloorRst;
        end
      endcase
      write_reg(REG_CUBE_LEN, len_v);
      write_reg(REG_TRIGGER, trig_v);
      write_reg(REG_SHIFT_FLOOR, floor_v);
      if (set == 2) write_reg(RegIdxSpare, RegW'($urandom));
      // one phase runs without any idling on either side
      calm = (set == 1);
      for (i = 0; i < RandPerSet; i++) begin
        // hold the sender until the block has drained
        if (set == 0 && i == RandPerSet / 2) settle();
        row = '0;
        row.n_boxes = -1;
        row.x = pick_coord(0);
        row.y = pick_coord(1);
        row.z = pick_coord(2);
        send_pos(row);
      end
      calm = 1'b0;
    end

    settle();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
